// ===== rtl/pdt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdt_pkg
// Shared types, constants and channel tables for the potentiometer servo
// deadband tracker.
// ---------------------------------------------------------------------------
package pdt_pkg;

    localparam int CH_W      = 2;
    localparam int CH_COUNT  = 4;
    localparam int SAMPLE_W  = 8;
    localparam int ANGLE_W   = 8;
    localparam int COMPARE_W = 12;
    localparam int DB_W      = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = DB_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 1'b1;

    localparam logic [DB_W-1:0]    DEADBAND_RESET = 4'd2;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET    = 8'd90;

    // s*100/d as (s * 100*ceil(2^26/d)) >> 26, exact for s < 256
    localparam int MAP_MUL_W  = 26;
    localparam int MAP_SHIFT  = 26;
    localparam int MAP_PROD_W = SAMPLE_W + MAP_MUL_W;

    // a*1333/100 as (a * 1333*ceil(2^25/100)) >> 25, exact for a < 256
    localparam int CMP_MUL_W  = 29;
    localparam int CMP_SHIFT  = 25;
    localparam int CMP_PROD_W = ANGLE_W + CMP_MUL_W;
    localparam logic [CMP_MUL_W-1:0] CMP_MUL = 29'd447281485;
    localparam logic [COMPARE_W-1:0] PULSE_BASE = 12'd800;
    localparam int PRESCALE_SHIFT = 3;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [ANGLE_W-1:0] mapped;
    } pdt_item_t;

    typedef struct packed {
        logic                 update;
        logic [CH_W-1:0]      servo;
        logic [ANGLE_W-1:0]   angle;
        logic [COMPARE_W-1:0] compare;
    } pdt_result_t;

    function automatic logic [MAP_MUL_W-1:0] map_mul(input logic [CH_W-1:0] ch);
        logic [MAP_MUL_W-1:0] m;
        case (ch)
            2'd0:    m = 26'd18186700;
            2'd1:    m = 26'd18693300;
            2'd2:    m = 26'd5528000;
            default: m = 26'd47259800;
        endcase
        return m;
    endfunction

    function automatic logic [ANGLE_W-1:0] map_offset(input logic [CH_W-1:0] ch);
        logic [ANGLE_W-1:0] o;
        case (ch)
            2'd0:    o = 8'd25;
            2'd1:    o = 8'd7;
            2'd2:    o = 8'd112;
            default: o = 8'd0;
        endcase
        return o;
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_low(input logic [CH_W-1:0] ch);
        logic [ANGLE_W-1:0] l;
        case (ch)
            2'd0:    l = 8'd25;
            2'd1:    l = 8'd7;
            2'd2:    l = 8'd112;
            default: l = 8'd0;
        endcase
        return l;
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_high(input logic [CH_W-1:0] ch);
        logic [ANGLE_W-1:0] h;
        case (ch)
            2'd0:    h = 8'd120;
            2'd1:    h = 8'd78;
            2'd2:    h = 8'd133;
            default: h = 8'd180;
        endcase
        return h;
    endfunction

endpackage

// ===== rtl/pdt_in_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdt_in_stage
// Input register: takes a request, maps the sample to a raw angle for its
// channel and holds it for the tracking stage.
// ---------------------------------------------------------------------------
module pdt_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pdt_pkg::CH_W-1:0]     channel,
    input  logic [pdt_pkg::SAMPLE_W-1:0] sample,
    output logic                        item_valid,
    input  logic                        item_ready,
    output pdt_pkg::pdt_item_t           item
);
    import pdt_pkg::*;

    logic                  valid_reg;
    pdt_item_t             item_reg;
    pdt_item_t             item_next;
    logic [MAP_PROD_W-1:0] map_prod;

    assign in_ready = !valid_reg || item_ready;

    always_comb
    begin
        map_prod          = MAP_PROD_W'(sample) * MAP_PROD_W'(map_mul(channel));
        item_next.channel = channel;
        item_next.mapped  = map_offset(channel) + map_prod[MAP_SHIFT +: ANGLE_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/pdt_track.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdt_track
// Per-channel angle store, deadband test, clamp, pulse compare and the
// result register.
// ---------------------------------------------------------------------------
module pdt_track (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  pdt_pkg::pdt_item_t             item,
    input  logic                          track_enable,
    input  logic [pdt_pkg::DB_W-1:0]       deadband,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pdt_pkg::pdt_result_t           result
);
    import pdt_pkg::*;

    logic [ANGLE_W-1:0]    angle_reg [CH_COUNT];
    logic [ANGLE_W-1:0]    angle_next;
    logic                  out_valid_reg;
    pdt_result_t           result_reg;
    pdt_result_t           result_next;
    logic                  load;
    logic                  hit;
    logic [ANGLE_W-1:0]    stored;
    logic [ANGLE_W-1:0]    diff;
    logic [CMP_PROD_W-1:0] cmp_prod;
    logic [COMPARE_W-1:0]  pulse;

    assign item_ready = !out_valid_reg || out_ready;
    assign load       = item_valid && item_ready;

    always_comb
    begin
        stored = angle_reg[item.channel];
        diff   = (item.mapped >= stored) ? item.mapped - stored : stored - item.mapped;
        hit    = track_enable && (diff > ANGLE_W'(deadband));

        angle_next = item.mapped;
        if (angle_next < angle_low(item.channel))
        begin
            angle_next = angle_low(item.channel);
        end
        if (angle_next > angle_high(item.channel))
        begin
            angle_next = angle_high(item.channel);
        end

        cmp_prod = CMP_PROD_W'(angle_next) * CMP_PROD_W'(CMP_MUL);
        pulse    = PULSE_BASE + cmp_prod[CMP_SHIFT +: COMPARE_W];
        // channels 2 and 3 run on the prescaled timer
        if (item.channel >= 2'd2)
        begin
            pulse = pulse >> PRESCALE_SHIFT;
        end

        result_next.update  = hit;
        result_next.servo   = item.channel;
        result_next.angle   = hit ? angle_next : stored;
        result_next.compare = hit ? pulse : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_COUNT; i++)
            begin
                angle_reg[i] <= ANGLE_RESET;
            end
        end
        else if (load && hit)
        begin
            angle_reg[item.channel] <= angle_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== rtl/pot_servo_deadband_tracker_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pot_servo_deadband_tracker_top
// Maps potentiometer samples of four servo channels to angles, applies the
// deadband and channel limits and gives the new pulse compare value on an update.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, channel, sample): one request per
//   sample. Output channel (out_valid/out_ready, update, servo, angle,
//   compare): exactly one result per request, in request order.
//   Path: a request passes the input register, then the result register.
//   Throughput: one request per cycle while out_ready is high; the stored
//   angle of a channel is read and rewritten in the same cycle, so
//   consecutive requests on one channel follow at full rate.
//   Configuration: cfg_we writes cfg_data into the register at cfg_index
//   (track_enable, deadband); the user writes only while idle; not enforced.
//   Reset: stored angles go to 90 degrees, tracking off, deadband 2.
//   Stall: the result register holds while out_ready is low; the input
//   register keeps its request, or takes one if it was empty, and in_ready
//   then stays low until out_ready returns.
// ---------------------------------------------------------------------------
module pot_servo_deadband_tracker_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pdt_pkg::CH_W-1:0]        channel,
    input  logic [pdt_pkg::SAMPLE_W-1:0]    sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           update,
    output logic [pdt_pkg::CH_W-1:0]        servo,
    output logic [pdt_pkg::ANGLE_W-1:0]     angle,
    output logic [pdt_pkg::COMPARE_W-1:0]   compare
);
    import pdt_pkg::*;

    logic              track_enable_reg;
    logic [DB_W-1:0]   deadband_reg;
    logic              item_valid;
    logic              item_ready;
    pdt_item_t         item;
    pdt_result_t       result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_enable_reg <= 1'b0;
            deadband_reg     <= DEADBAND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TRACK_ENABLE: track_enable_reg <= cfg_data[0];
                REG_DEADBAND:     deadband_reg     <= cfg_data[DB_W-1:0];
                default:          ;
            endcase
        end
    end

    pdt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .channel    (channel),
        .sample     (sample),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    pdt_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .track_enable (track_enable_reg),
        .deadband     (deadband_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result       (result)
    );

    assign update  = result.update;
    assign servo   = result.servo;
    assign angle   = result.angle;
    assign compare = result.compare;

endmodule

// ===== rtl/pdt_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdt_checker
// Port-level checks for the servo deadband tracker, bound to the top level.
// ---------------------------------------------------------------------------
module pdt_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           update,
    input  logic [pdt_pkg::CH_W-1:0]        servo,
    input  logic [pdt_pkg::ANGLE_W-1:0]     angle,
    input  logic [pdt_pkg::COMPARE_W-1:0]   compare
);
    import pdt_pkg::*;

    // back-pressure only ever comes from a stalled result
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a stalled result");

    a_no_update_no_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !update) |-> (compare == '0))
        else $error("compare set on a result without update");

    a_update_has_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && update) |-> (compare != '0) && (angle <= ANGLE_W'(180)))
        else $error("bad compare or angle on an update");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(update) && $stable(servo) && $stable(angle)
             && $stable(compare)))
        else $error("result changed while stalled");

endmodule

bind pot_servo_deadband_tracker_top pdt_checker u_pdt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .update    (update),
    .servo     (servo),
    .angle     (angle),
    .compare   (compare)
);
